FILE: sv/lru_frame_cache_budget_macros.svh
// Assertion macros shared by the frame cache RTL.
`ifndef LRU_FRAME_CACHE_BUDGET_MACROS_SVH
`define LRU_FRAME_CACHE_BUDGET_MACROS_SVH

// Same-cycle implication, checked on the rising edge of clk outside reset.
`define LFCB_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on the rising edge of clk outside reset.
`define LFCB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: sv/lfcb_pkg.sv
// Types, constants and helper functions of the frame cache slot manager.
`default_nettype none

package lfcb_pkg;

  localparam logic [24:0] BUDGET_DEFAULT = 25'd2097152;
  localparam logic [24:0] BUDGET_FLOOR   = 25'd65536;
  localparam logic [24:0] BYTES_MAX      = 25'h1FFFFFF;

  localparam logic OP_REQUEST = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  localparam logic [2:0] LOAD_OK          = 3'd0;
  localparam logic [2:0] LOAD_NOT_MOUNTED = 3'd1;
  localparam logic [2:0] LOAD_OPEN        = 3'd2;
  localparam logic [2:0] LOAD_SHORT       = 3'd3;
  localparam logic [2:0] LOAD_READ        = 3'd4;

  localparam logic [2:0] STAT_OK          = 3'd0;
  localparam logic [2:0] STAT_NO_KEY      = 3'd1;
  localparam logic [2:0] STAT_BAD_SIZE    = 3'd2;
  localparam logic [2:0] STAT_NOT_MOUNTED = 3'd3;
  localparam logic [2:0] STAT_OPEN        = 3'd4;
  localparam logic [2:0] STAT_SHORT       = 3'd5;
  localparam logic [2:0] STAT_READ        = 3'd6;
  localparam logic [2:0] STAT_MEMORY      = 3'd7;

  typedef enum logic [3:0] {
    S_IDLE,
    S_HSCAN,
    S_CHK0,
    S_CHK,
    S_LSCAN,
    S_FMUL,
    S_FUPD,
    S_LOAD,
    S_REL
  } state_t;

  typedef struct packed {
    logic [31:0] key;
    logic [11:0] width;
    logic [11:0] height;
    logic        alpha;
    logic [31:0] age;
  } entry_t;

  // Bytes taken by a frame of n pixels: two per pixel, one more with alpha.
  function automatic logic [25:0] footprint(input logic [23:0] n, input logic a);
    logic [25:0] base;
    logic [25:0] extra;
    base  = {1'b0, n, 1'b0};
    extra = a ? {2'b00, n} : 26'd0;
    return base + extra;
  endfunction

  function automatic logic [2:0] load_status(input logic [2:0] ld);
    logic [2:0] st;
    case (ld)
      LOAD_NOT_MOUNTED: st = STAT_NOT_MOUNTED;
      LOAD_OPEN:        st = STAT_OPEN;
      LOAD_SHORT:       st = STAT_SHORT;
      LOAD_READ:        st = STAT_READ;
      default:          st = STAT_MEMORY;
    endcase
    return st;
  endfunction

endpackage

`default_nettype wire

FILE: sv/lru_frame_cache_budget.sv
// Top level of the LRU frame cache slot manager with a byte budget.
`default_nettype none
`include "lru_frame_cache_budget_macros.svh"

// Usage.
// A command is taken at a rising clock edge where start is high and busy is low; its
// fields sit on the in_ ports at that edge. opcode 0 looks a frame up and, on a miss,
// evicts least recently used slots until the frame fits the byte budget and a slot is
// free, then fills a slot if the load succeeded. opcode 1 releases every slot.
// Each command gives exactly one result, shown on the out_ ports for one cycle with
// out_valid high; the receiver cannot stall, so it must take the transfer then.
// Commands rejected up front (no key, zero size) report the cycle after the transfer.
// The slot table sits in a RAM that is read one slot per cycle; the hit scan walks it
// until a match and the LRU scan walks all of it, one entry at a time. Entry footprints
// come from one shared 12 by 12 multiplier. busy stays high from the transfer until the
// result of every command that is not rejected up front.
// cfg_we writes the byte budget; the user must use it only while the block is idle, which
// the block itself does not enforce. Values below 64 KiB are raised to 64 KiB.
// Reset (rst_n low at a clock edge) clears all slot valid bits, the age counter and
// the byte count, and restores the 2 MiB budget; no clearing pass is needed.

module lru_frame_cache_budget #(
  parameter int SLOT_COUNT = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        in_opcode,
  input  wire logic [31:0] in_key_id,
  input  wire logic        in_key_present,
  input  wire logic [11:0] in_frame_width,
  input  wire logic [11:0] in_frame_height,
  input  wire logic [2:0]  in_load_result,
  input  wire logic        in_alpha_loaded,
  output logic             out_valid,
  output logic             out_hit,
  output logic [2:0]       out_status,
  output logic [4:0]       out_slot_index,
  output logic             out_frame_has_alpha,
  output logic [5:0]       out_evicted_count,
  output logic [24:0]      out_bytes_used,
  input  wire logic        cfg_we,
  input  wire logic [24:0] cfg_wdata
);

  localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int CNT_W = $clog2(SLOT_COUNT + 1);
  localparam logic [CNT_W-1:0] SLOT_CNT = CNT_W'(SLOT_COUNT);
  localparam int ENT_W = $bits(lfcb_pkg::entry_t);

  // Sequencer and bookkeeping registers.
  lfcb_pkg::state_t  state_r, state_nxt;
  logic [24:0]       budget_r, budget_nxt;
  logic [SLOT_COUNT-1:0] valid_r, valid_nxt;
  logic [31:0]       age_r, age_nxt;
  logic [24:0]       occ_r, occ_nxt;

  // Latched command.
  logic [31:0]       req_key_r, req_key_nxt;
  logic [11:0]       req_w_r, req_w_nxt;
  logic [11:0]       req_h_r, req_h_nxt;
  logic [2:0]        req_load_r, req_load_nxt;
  logic              req_alpha_r, req_alpha_nxt;
  logic [23:0]       req_n_r, req_n_nxt;
  logic [23:0]       prod_r, prod_nxt;

  // Scan pipeline: the address goes out one cycle, its entry comes back the next.
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              rd_vld_r, rd_vld_nxt;
  logic [IDX_W-1:0]  rd_idx_r, rd_idx_nxt;

  // Results of the LRU and empty-slot scan.
  logic              evict_mode_r, evict_mode_nxt;
  logic              then_load_r, then_load_nxt;
  logic              lru_found_r, lru_found_nxt;
  logic [31:0]       best_age_r, best_age_nxt;
  logic [IDX_W-1:0]  best_idx_r, best_idx_nxt;
  logic [11:0]       best_w_r, best_w_nxt;
  logic [11:0]       best_h_r, best_h_nxt;
  logic              best_a_r, best_a_nxt;
  logic              empty_found_r, empty_found_nxt;
  logic [IDX_W-1:0]  empty_idx_r, empty_idx_nxt;
  logic [IDX_W-1:0]  pick_r, pick_nxt;
  logic [5:0]        evict_cnt_r, evict_cnt_nxt;

  // Result registers.
  logic              out_valid_r, out_valid_nxt;
  logic              out_hit_r, out_hit_nxt;
  logic [2:0]        out_status_r, out_status_nxt;
  logic [4:0]        out_slot_r, out_slot_nxt;
  logic              out_alpha_r, out_alpha_nxt;
  logic [5:0]        out_evict_r, out_evict_nxt;
  logic [24:0]       out_bytes_r, out_bytes_nxt;

  // Slot table RAM.
  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  lfcb_pkg::entry_t  ram_wdata;
  logic [IDX_W-1:0]  ram_raddr;
  logic [ENT_W-1:0]  ram_rdata;
  lfcb_pkg::entry_t  rd_ent;

  // The one multiplier: command size at acceptance, a victim's size when it is freed.
  logic [11:0]       mul_a;
  logic [11:0]       mul_b;
  logic [23:0]       mul_p;

  // Combinational helpers.
  logic              accept;
  logic              issue;
  logic              scan_done;
  logic              rd_slot_valid;
  logic              hit_match;
  logic [25:0]       fp_need;
  logic [26:0]       need_sum;
  logic [25:0]       fp_victim;
  logic [25:0]       fp_fill;
  logic [26:0]       fill_sum;
  logic [24:0]       occ_fill;

  assign accept = start && (state_r == lfcb_pkg::S_IDLE);
  assign busy   = (state_r != lfcb_pkg::S_IDLE);

  lfcb_ram #(
    .WIDTH (ENT_W),
    .DEPTH (SLOT_COUNT)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_ent = lfcb_pkg::entry_t'(ram_rdata);

  assign mul_a = (state_r == lfcb_pkg::S_IDLE) ? in_frame_width : best_w_r;
  assign mul_b = (state_r == lfcb_pkg::S_IDLE) ? in_frame_height : best_h_r;
  assign mul_p = mul_a * mul_b;

  assign issue         = (cnt_r < SLOT_CNT);
  assign scan_done     = !issue && !rd_vld_r;
  assign rd_slot_valid = rd_vld_r && valid_r[rd_idx_r];
  assign hit_match     = rd_slot_valid && (rd_ent.key == req_key_r) &&
                         (rd_ent.width == req_w_r) && (rd_ent.height == req_h_r);

  // Worst-case footprint (with alpha) that the budget check reserves.
  assign fp_need  = lfcb_pkg::footprint(req_n_r, 1'b1);
  assign need_sum = {2'b00, occ_r} + {1'b0, fp_need};
  assign fp_victim = lfcb_pkg::footprint(prod_r, best_a_r);
  assign fp_fill  = lfcb_pkg::footprint(req_n_r, req_alpha_r);
  assign fill_sum = {2'b00, occ_r} + {1'b0, fp_fill};
  assign occ_fill = (fill_sum > {2'b00, lfcb_pkg::BYTES_MAX}) ? lfcb_pkg::BYTES_MAX
                                                              : fill_sum[24:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lfcb_pkg::S_IDLE;
      budget_r    <= lfcb_pkg::BUDGET_DEFAULT;
      valid_r     <= '0;
      age_r       <= '0;
      occ_r       <= '0;
      cnt_r       <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      budget_r    <= budget_nxt;
      valid_r     <= valid_nxt;
      age_r       <= age_nxt;
      occ_r       <= occ_nxt;
      cnt_r       <= cnt_nxt;
      rd_vld_r    <= rd_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_key_r     <= req_key_nxt;
    req_w_r       <= req_w_nxt;
    req_h_r       <= req_h_nxt;
    req_load_r    <= req_load_nxt;
    req_alpha_r   <= req_alpha_nxt;
    req_n_r       <= req_n_nxt;
    prod_r        <= prod_nxt;
    rd_idx_r      <= rd_idx_nxt;
    evict_mode_r  <= evict_mode_nxt;
    then_load_r   <= then_load_nxt;
    lru_found_r   <= lru_found_nxt;
    best_age_r    <= best_age_nxt;
    best_idx_r    <= best_idx_nxt;
    best_w_r      <= best_w_nxt;
    best_h_r      <= best_h_nxt;
    best_a_r      <= best_a_nxt;
    empty_found_r <= empty_found_nxt;
    empty_idx_r   <= empty_idx_nxt;
    pick_r        <= pick_nxt;
    evict_cnt_r   <= evict_cnt_nxt;
    out_hit_r     <= out_hit_nxt;
    out_status_r  <= out_status_nxt;
    out_slot_r    <= out_slot_nxt;
    out_alpha_r   <= out_alpha_nxt;
    out_evict_r   <= out_evict_nxt;
    out_bytes_r   <= out_bytes_nxt;
  end

  always_comb begin
    state_nxt       = state_r;
    budget_nxt      = budget_r;
    valid_nxt       = valid_r;
    age_nxt         = age_r;
    occ_nxt         = occ_r;
    req_key_nxt     = req_key_r;
    req_w_nxt       = req_w_r;
    req_h_nxt       = req_h_r;
    req_load_nxt    = req_load_r;
    req_alpha_nxt   = req_alpha_r;
    req_n_nxt       = req_n_r;
    prod_nxt        = prod_r;
    cnt_nxt         = cnt_r;
    rd_vld_nxt      = 1'b0;
    rd_idx_nxt      = rd_idx_r;
    evict_mode_nxt  = evict_mode_r;
    then_load_nxt   = then_load_r;
    lru_found_nxt   = lru_found_r;
    best_age_nxt    = best_age_r;
    best_idx_nxt    = best_idx_r;
    best_w_nxt      = best_w_r;
    best_h_nxt      = best_h_r;
    best_a_nxt      = best_a_r;
    empty_found_nxt = empty_found_r;
    empty_idx_nxt   = empty_idx_r;
    pick_nxt        = pick_r;
    evict_cnt_nxt   = evict_cnt_r;
    out_valid_nxt   = 1'b0;
    out_hit_nxt     = out_hit_r;
    out_status_nxt  = out_status_r;
    out_slot_nxt    = out_slot_r;
    out_alpha_nxt   = out_alpha_r;
    out_evict_nxt   = out_evict_r;
    out_bytes_nxt   = out_bytes_r;
    ram_we          = 1'b0;
    ram_waddr       = rd_idx_r;
    ram_wdata       = rd_ent;
    ram_raddr       = cnt_r[IDX_W-1:0];

    if (cfg_we) begin
      budget_nxt = (cfg_wdata < lfcb_pkg::BUDGET_FLOOR) ? lfcb_pkg::BUDGET_FLOOR : cfg_wdata;
    end

    // Both table scans share this address walk.
    if ((state_r == lfcb_pkg::S_HSCAN) || (state_r == lfcb_pkg::S_LSCAN)) begin
      if (issue) begin
        cnt_nxt    = cnt_r + CNT_W'(1);
        rd_vld_nxt = 1'b1;
        rd_idx_nxt = cnt_r[IDX_W-1:0];
      end
    end

    case (state_r)
      lfcb_pkg::S_IDLE: begin
        if (accept) begin
          req_key_nxt   = in_key_id;
          req_w_nxt     = in_frame_width;
          req_h_nxt     = in_frame_height;
          req_load_nxt  = in_load_result;
          req_alpha_nxt = in_alpha_loaded;
          req_n_nxt     = mul_p;
          evict_cnt_nxt = '0;
          cnt_nxt       = '0;
          out_hit_nxt   = 1'b0;
          out_slot_nxt  = '0;
          out_alpha_nxt = 1'b0;
          out_evict_nxt = '0;
          out_bytes_nxt = occ_r;
          if (in_opcode == lfcb_pkg::OP_RELEASE) begin
            state_nxt = lfcb_pkg::S_REL;
          end else if (!in_key_present) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = lfcb_pkg::STAT_NO_KEY;
          end else if ((in_frame_width == 12'd0) || (in_frame_height == 12'd0)) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = lfcb_pkg::STAT_BAD_SIZE;
          end else begin
            state_nxt = lfcb_pkg::S_HSCAN;
          end
        end
      end

      lfcb_pkg::S_HSCAN: begin
        if (hit_match) begin
          // Refresh the age stamp of the matching slot and report the hit.
          age_nxt        = age_r + 32'd1;
          ram_we         = 1'b1;
          ram_waddr      = rd_idx_r;
          ram_wdata      = rd_ent;
          ram_wdata.age  = age_r + 32'd1;
          rd_vld_nxt     = 1'b0;
          out_valid_nxt  = 1'b1;
          out_hit_nxt    = 1'b1;
          out_status_nxt = lfcb_pkg::STAT_OK;
          out_slot_nxt   = 5'(rd_idx_r);
          out_alpha_nxt  = rd_ent.alpha;
          state_nxt      = lfcb_pkg::S_IDLE;
        end else if (scan_done) begin
          state_nxt = lfcb_pkg::S_CHK0;
        end
      end

      lfcb_pkg::S_CHK0: begin
        // A frame that cannot fit even without alpha is refused outright.
        if ({req_n_r, 1'b0} > budget_r) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = lfcb_pkg::STAT_BAD_SIZE;
          state_nxt      = lfcb_pkg::S_IDLE;
        end else begin
          state_nxt = lfcb_pkg::S_CHK;
        end
      end

      lfcb_pkg::S_CHK: begin
        evict_mode_nxt  = (need_sum > {2'b00, budget_r}) && (|valid_r);
        then_load_nxt   = 1'b0;
        lru_found_nxt   = 1'b0;
        empty_found_nxt = 1'b0;
        cnt_nxt         = '0;
        state_nxt       = lfcb_pkg::S_LSCAN;
      end

      lfcb_pkg::S_LSCAN: begin
        if (rd_vld_r) begin
          if (valid_r[rd_idx_r]) begin
            if (!lru_found_r || (rd_ent.age < best_age_r)) begin
              lru_found_nxt = 1'b1;
              best_age_nxt  = rd_ent.age;
              best_idx_nxt  = rd_idx_r;
              best_w_nxt    = rd_ent.width;
              best_h_nxt    = rd_ent.height;
              best_a_nxt    = rd_ent.alpha;
            end
          end else if (!empty_found_r) begin
            empty_found_nxt = 1'b1;
            empty_idx_nxt   = rd_idx_r;
          end
        end
        if (scan_done) begin
          if (evict_mode_r) begin
            state_nxt = lfcb_pkg::S_FMUL;
          end else if (empty_found_r) begin
            pick_nxt  = empty_idx_r;
            state_nxt = lfcb_pkg::S_LOAD;
          end else if (lru_found_r) begin
            // Table full: the least recently used slot makes room.
            pick_nxt      = best_idx_r;
            then_load_nxt = 1'b1;
            state_nxt     = lfcb_pkg::S_FMUL;
          end else begin
            pick_nxt  = '0;
            state_nxt = lfcb_pkg::S_LOAD;
          end
        end
      end

      lfcb_pkg::S_FMUL: begin
        prod_nxt  = mul_p;
        state_nxt = lfcb_pkg::S_FUPD;
      end

      lfcb_pkg::S_FUPD: begin
        occ_nxt   = ({1'b0, occ_r} >= fp_victim) ? 25'({1'b0, occ_r} - fp_victim) : 25'd0;
        valid_nxt[best_idx_r] = 1'b0;
        evict_cnt_nxt = evict_cnt_r + 6'd1;
        state_nxt = then_load_r ? lfcb_pkg::S_LOAD : lfcb_pkg::S_CHK;
        out_bytes_nxt = occ_nxt;
        out_evict_nxt = evict_cnt_nxt;
      end

      lfcb_pkg::S_LOAD: begin
        out_valid_nxt = 1'b1;
        out_evict_nxt = evict_cnt_r;
        state_nxt     = lfcb_pkg::S_IDLE;
        if (req_load_r != lfcb_pkg::LOAD_OK) begin
          out_status_nxt = lfcb_pkg::load_status(req_load_r);
          out_bytes_nxt  = occ_r;
        end else begin
          ram_we           = 1'b1;
          ram_waddr        = pick_r;
          ram_wdata.key    = req_key_r;
          ram_wdata.width  = req_w_r;
          ram_wdata.height = req_h_r;
          ram_wdata.alpha  = req_alpha_r;
          ram_wdata.age    = age_r + 32'd1;
          age_nxt          = age_r + 32'd1;
          valid_nxt[pick_r] = 1'b1;
          occ_nxt          = occ_fill;
          out_status_nxt   = lfcb_pkg::STAT_OK;
          out_slot_nxt     = 5'(pick_r);
          out_alpha_nxt    = req_alpha_r;
          out_bytes_nxt    = occ_fill;
        end
      end

      lfcb_pkg::S_REL: begin
        if (issue) begin
          if (valid_r[cnt_r[IDX_W-1:0]]) begin
            evict_cnt_nxt = evict_cnt_r + 6'd1;
          end
          valid_nxt[cnt_r[IDX_W-1:0]] = 1'b0;
          cnt_nxt = cnt_r + CNT_W'(1);
        end else begin
          occ_nxt        = '0;
          out_valid_nxt  = 1'b1;
          out_status_nxt = lfcb_pkg::STAT_OK;
          out_evict_nxt  = evict_cnt_r;
          out_bytes_nxt  = '0;
          state_nxt      = lfcb_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = lfcb_pkg::S_IDLE;
      end
    endcase
  end

  assign out_valid           = out_valid_r;
  assign out_hit             = out_hit_r;
  assign out_status          = out_status_r;
  assign out_slot_index      = out_slot_r;
  assign out_frame_has_alpha = out_alpha_r;
  assign out_evicted_count   = out_evict_r;
  assign out_bytes_used      = out_bytes_r;

  // An accepted command either reports at once or keeps the block busy.
  `LFCB_ASSERT_NEXT(a_accept_progress, start && !busy, busy || out_valid, "command lost after transfer")
  // A result is only shown once the sequencer has returned to idle.
  `LFCB_ASSERT_IMPLY(a_result_idle, out_valid, !busy, "result strobe while busy")
  // Failed requests carry no slot information.
  `LFCB_ASSERT_IMPLY(a_fail_fields, out_valid && (out_status != lfcb_pkg::STAT_OK), !out_hit && (out_slot_index == 5'd0) && !out_frame_has_alpha, "failed result carries slot data")
  // The budget register never drops below its floor.
  `LFCB_ASSERT_IMPLY(a_budget_floor, 1'b1, budget_r >= lfcb_pkg::BUDGET_FLOOR, "budget below floor")

endmodule

`default_nettype wire

FILE: sv/lfcb_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module lfcb_ram #(
  parameter int WIDTH = 89,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire
